FILE: sv/bbs_pkg.sv
// ----------------------------------------------------------------------------
// bbs_pkg: shared definitions for the breakpoint binary search unit
// Field widths, item kinds and sequencer states used by the search unit.
// ----------------------------------------------------------------------------
package bbs_pkg;

  // Payload field widths.
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned ENTRY_W   = 4;
  localparam int unsigned RESULT_W  = 5;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 8;

  // Result code for a value below entry 0.
  localparam logic [RESULT_W-1:0] NOT_FOUND = 5'h1F;

  // Item kinds carried in tuser.
  typedef enum logic {
    ACT_WRITE  = 1'b0,
    ACT_SEARCH = 1'b1
  } bbs_action_e;

  // Search sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK0,
    ST_PROBE,
    ST_HOLD
  } bbs_state_e;

endpackage

FILE: sv/bbs_ram.sv
// ----------------------------------------------------------------------------
// bbs_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bbs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/breakpoint_binary_search_unit.sv
// ----------------------------------------------------------------------------
// breakpoint_binary_search_unit: floor search over a sorted breakpoint table
// Holds a table of signed Q16.16 breakpoints loaded by write items and
// returns, for each search item, the highest index whose entry is less than
// or equal to the searched value, or -1 when the value is below entry 0.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload (lowest bit first)
//  -------   ---------  ---------------------------------------------------
//  s_axis    in         tuser: action; tdata: entry_index[3:0],
//                       data_value[35:4], zero fill [39:36]
//  m_axis    out        tdata: found_index[4:0], zero fill [7:5]
//
// A write item is written into the table RAM at the transfer, and the unit
// stays ready for the next item. A search item first reads entry 0 for the
// below-table check, then makes one RAM read and one signed compare per
// index bit through the single compare unit before its result is registered
// at the output. The unit takes no new item while a search runs. A finished
// result that finds the output register still occupied waits in place until
// the downstream side takes the earlier one. Reset returns the sequencer to
// idle and empties the output register; table contents are kept as
// undefined until written.
module breakpoint_binary_search_unit #(
  parameter int unsigned TABLE_SIZE = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input stream.
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // tdata: entry_index[3:0], data_value[35:4], zero [39:36]
  input  logic [bbs_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // tuser: action (0 write, 1 search)
  input  logic                               s_axis_tuser_i,
  // Result stream.
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // tdata: found_index[4:0], zero [7:5]
  output logic [bbs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o
);

  import bbs_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_SIZE);
  localparam logic [IDX_W-1:0] TOP_BIT = IDX_W'(TABLE_SIZE / 2);

  // Unpacked input fields.
  logic [ENTRY_W-1:0] in_entry;
  logic [DATA_W-1:0]  in_value;
  logic               in_xfer;

  // Sequencer and search state.
  bbs_state_e        state_q, state_d;
  logic [IDX_W-1:0]  idx_q, idx_d;        // index built so far
  logic [IDX_W-1:0]  bit_q, bit_d;        // index bit under trial
  logic              zero_le_q, zero_le_d; // entry 0 <= value
  logic [DATA_W-1:0] value_q, value_d;    // searched value

  // The unit only takes items while the sequencer is idle.
  assign s_axis_tready_o = (state_q == ST_IDLE);

  assign in_entry = s_axis_tdata_i[ENTRY_W-1:0];
  assign in_value = s_axis_tdata_i[ENTRY_W+DATA_W-1:ENTRY_W];
  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;

  // Output register.
  logic                out_valid_q, out_valid_d;
  logic [RESULT_W-1:0] out_data_q, out_data_d;
  logic                out_free;

  // Table RAM ports.
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [IDX_W-1:0]  ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  // Shared compare unit: table entry read this cycle against the value.
  logic              entry_le;
  logic [IDX_W-1:0]  probe;
  logic [31:0]       entry_mask;
  logic [31:0]       idx_wide;

  assign entry_le = $signed(ram_rdata) <= $signed(value_q);
  assign probe    = idx_q | bit_q;
  assign out_free = !out_valid_q || m_axis_tready_i;

  // The write position is the entry field masked to the table size; a
  // power-of-two table keeps every masked position in range.
  assign entry_mask = 32'(in_entry) & 32'(TABLE_SIZE - 1);
  assign ram_waddr  = entry_mask[IDX_W-1:0];
  assign ram_we     = in_xfer && (s_axis_tuser_i == ACT_WRITE);

  bbs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TABLE_SIZE)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_value),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Result code: the built index, or not-found when nothing was at or below
  // the value (index zero and entry 0 above the value).
  assign idx_wide = 32'(idx_d);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    bit_d       = bit_q;
    zero_le_d   = zero_le_q;
    value_d     = value_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_data_d  = out_data_q;
    ram_raddr   = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer && (s_axis_tuser_i == ACT_SEARCH)) begin
          // Start by reading entry 0 for the below-table check.
          value_d   = in_value;
          ram_raddr = '0;
          state_d   = ST_CHECK0;
        end
      end

      ST_CHECK0: begin
        zero_le_d = entry_le;
        idx_d     = '0;
        bit_d     = TOP_BIT;
        ram_raddr = TOP_BIT;
        state_d   = ST_PROBE;
      end

      ST_PROBE: begin
        // Keep the probed bit when its entry is at or below the value.
        if (entry_le) begin
          idx_d = probe;
        end
        bit_d     = bit_q >> 1;
        ram_raddr = idx_d | bit_d;
        if (bit_d == '0) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_data_d  = (idx_d != '0 || zero_le_q) ? idx_wide[RESULT_W-1:0]
                                                     : NOT_FOUND;
            state_d     = ST_IDLE;
          end else begin
            state_d = ST_HOLD;
          end
        end
      end

      ST_HOLD: begin
        // Finished result waits for the output register to drain.
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = (idx_d != '0 || zero_le_q) ? idx_wide[RESULT_W-1:0]
                                                   : NOT_FOUND;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      bit_q       <= '0;
      zero_le_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      bit_q       <= bit_d;
      zero_le_q   <= zero_le_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q    <= value_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_TDATA_W - RESULT_W){1'b0}}, out_data_q};

endmodule
